// ===== rtl/core/line_pixel_rasterizer_assert.svh =====
// Assertion macros used by the line rasterizer top level.
`ifndef LINE_PIXEL_RASTERIZER_ASSERT_SVH
`define LINE_PIXEL_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lpr_pkg.sv =====
// Package for the line rasterizer: widths, FSM states, control structs.
`default_nettype none
package lpr_pkg;

    localparam int COORD_W = 6;
    localparam int COLOR_W = 24;
    localparam int ERR_W   = 9;

    localparam logic [COORD_W-1:0] COORD_MAX = 6'd63;

    // config register indexes
    localparam logic REG_LINE_ENABLED = 1'b0;
    localparam logic REG_LINE_COLOR   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;   // capture the command beat
        logic setup;  // derive walk parameters
        logic step;   // advance to the next pixel
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic last;   // current pixel is the final one
    } t_dp_stat;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
        return (c > COORD_MAX) ? COORD_MAX : c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lpr_ctrl.sv =====
// Controller FSM for the line rasterizer: accept, setup, pixel emission.
`default_nettype none
module lpr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_enabled,
    input  wire logic              i_out_ready,
    input  wire lpr_pkg::t_dp_stat i_stat,
    output lpr_pkg::t_dp_cmd       o_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_valid
);
    import lpr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                // line disabled: beat is consumed, nothing drawn
                if (i_in_valid && i_enabled) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_ready && i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.step  = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/lpr_dpath.sv =====
// Datapath for the line rasterizer: command capture, setup, Bresenham step.
`default_nettype none
module lpr_dpath (
    input  wire logic                    i_clk,
    input  wire lpr_pkg::t_dp_cmd        i_cmd,
    input  wire logic [lpr_pkg::COORD_W-1:0] i_start_x,
    input  wire logic [lpr_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [lpr_pkg::COORD_W-1:0] i_end_x,
    input  wire logic [lpr_pkg::COORD_W-1:0] i_end_y,
    output lpr_pkg::t_dp_stat            o_stat,
    output logic [lpr_pkg::COORD_W-1:0]  o_pixel_x,
    output logic [lpr_pkg::COORD_W-1:0]  o_pixel_y
);
    import lpr_pkg::*;

    // captured endpoints
    logic [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;

    // walk state
    logic                    r_ymaj;
    logic                    r_major_down;
    logic                    r_minor_down;
    logic [COORD_W-1:0]      r_major;
    logic [COORD_W-1:0]      r_minor;
    logic [COORD_W-1:0]      r_stop;
    logic signed [ERR_W-1:0] r_err;
    logic signed [ERR_W-1:0] r_inc;
    logic signed [ERR_W-1:0] r_dec;

    logic                    n_ymaj;
    logic                    n_major_down;
    logic                    n_minor_down;
    logic [COORD_W-1:0]      n_major;
    logic [COORD_W-1:0]      n_minor;
    logic [COORD_W-1:0]      n_stop;
    logic signed [ERR_W-1:0] n_err;
    logic signed [ERR_W-1:0] n_inc;
    logic signed [ERR_W-1:0] n_dec;

    logic [COORD_W-1:0]      dx, dy, dmaj, dmin;
    logic                    xmaj;
    logic signed [ERR_W-1:0] inc2, maj2, maj1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx <= clamp_coord(i_start_x);
            r_sy <= clamp_coord(i_start_y);
            r_ex <= clamp_coord(i_end_x);
            r_ey <= clamp_coord(i_end_y);
        end
    end

    always_comb begin
        dx   = (r_ex > r_sx) ? (r_ex - r_sx) : (r_sx - r_ex);
        dy   = (r_ey > r_sy) ? (r_ey - r_sy) : (r_sy - r_ey);
        xmaj = (dx >= dy);
        dmaj = xmaj ? dx : dy;
        dmin = xmaj ? dy : dx;
        inc2 = $signed({2'b00, dmin, 1'b0});
        maj2 = $signed({2'b00, dmaj, 1'b0});
        maj1 = $signed({3'b000, dmaj});
    end

    always_comb begin
        n_ymaj       = r_ymaj;
        n_major_down = r_major_down;
        n_minor_down = r_minor_down;
        n_major      = r_major;
        n_minor      = r_minor;
        n_stop       = r_stop;
        n_err        = r_err;
        n_inc        = r_inc;
        n_dec        = r_dec;
        if (i_cmd.setup) begin
            if (r_sx == r_ex || r_sy == r_ey) begin
                // axis-aligned: walk start to end, minor never steps (err stays -1)
                n_ymaj       = (r_sx == r_ex);
                n_major      = n_ymaj ? r_sy : r_sx;
                n_minor      = n_ymaj ? r_sx : r_sy;
                n_stop       = n_ymaj ? r_ey : r_ex;
                n_major_down = n_ymaj ? (r_ey < r_sy) : (r_ex < r_sx);
                n_minor_down = 1'b0;
                n_err        = -9'sd1;
                n_inc        = '0;
                n_dec        = '0;
            end else begin
                // start at the end with the smaller major coordinate
                n_ymaj       = !xmaj;
                n_major_down = 1'b0;
                if (xmaj) begin
                    if (r_sx < r_ex) begin
                        n_major = r_sx; n_minor = r_sy; n_stop = r_ex;
                        n_minor_down = (r_ey < r_sy);
                    end else begin
                        n_major = r_ex; n_minor = r_ey; n_stop = r_sx;
                        n_minor_down = (r_sy < r_ey);
                    end
                end else begin
                    if (r_sy < r_ey) begin
                        n_major = r_sy; n_minor = r_sx; n_stop = r_ey;
                        n_minor_down = (r_ex < r_sx);
                    end else begin
                        n_major = r_ey; n_minor = r_ex; n_stop = r_sy;
                        n_minor_down = (r_sx < r_ex);
                    end
                end
                n_inc = inc2;
                n_dec = inc2 - maj2;
                n_err = inc2 - maj1;
            end
        end else if (i_cmd.step) begin
            n_major = r_major_down ? (r_major - 1'b1) : (r_major + 1'b1);
            if (r_err[ERR_W-1]) begin
                n_err = r_err + r_inc;
            end else begin
                n_err   = r_err + r_dec;
                n_minor = r_minor_down ? (r_minor - 1'b1) : (r_minor + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ymaj       <= n_ymaj;
        r_major_down <= n_major_down;
        r_minor_down <= n_minor_down;
        r_major      <= n_major;
        r_minor      <= n_minor;
        r_stop       <= n_stop;
        r_err        <= n_err;
        r_inc        <= n_inc;
        r_dec        <= n_dec;
    end

    assign o_stat.last = (r_major == r_stop);
    assign o_pixel_x   = r_ymaj ? r_minor : r_major;
    assign o_pixel_y   = r_ymaj ? r_major : r_minor;

endmodule
`default_nettype wire

// ===== rtl/core/line_pixel_rasterizer.sv =====
// Line rasterizer top level: config registers, controller, datapath, checks.
//
// Usage:
//   s_axis carries one line command per beat (start and end points in a
//   64 by 64 tile). m_axis returns one beat per pixel with the pixel
//   position and the line colour; tlast marks the final pixel.
//   The config port writes line_enabled (index 0) and line_color (index 1);
//   the user must write them only while the block is idle, which the block does not enforce.
// Timing:
//   A command is taken only while no line is in flight. A setup state
//   follows the command beat, then pixels come out one per cycle while
//   m_axis_tready is high. The rate is set by the single Bresenham
//   stepper, which produces one pixel per cycle while m_axis_tready is
//   high. With line_enabled low a command beat is consumed and produces
//   no pixels.
// Reset: synchronous, active low; clears the controller and both config
//   registers. Stalls: a low m_axis_tready holds the current pixel beat
//   and freezes the stepper.
`default_nettype none
module line_pixel_rasterizer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // config write port
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [lpr_pkg::COLOR_W-1:0]  i_cfg_data,
    // command stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18]
    input  wire logic [23:0]                  s_axis_tdata,
    // pixel stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // tdata: pixel_x[5:0], pixel_y[11:6], pixel_color[35:12], zero[39:36]
    output logic [39:0]                       m_axis_tdata,
    // tlast: last_pixel
    output logic                              m_axis_tlast
);
    import lpr_pkg::*;

    logic               r_line_enabled;
    logic [COLOR_W-1:0] r_line_color;

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_enabled <= 1'b0;
            r_line_color   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LINE_ENABLED: r_line_enabled <= i_cfg_data[0];
                REG_LINE_COLOR:   r_line_color   <= i_cfg_data;
                default:          r_line_color   <= r_line_color;
            endcase
        end
    end

    lpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_enabled   (r_line_enabled),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    lpr_dpath u_dpath (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_start_x (s_axis_tdata[5:0]),
        .i_start_y (s_axis_tdata[11:6]),
        .i_end_x   (s_axis_tdata[17:12]),
        .i_end_y   (s_axis_tdata[23:18]),
        .o_stat    (stat),
        .o_pixel_x (pixel_x),
        .o_pixel_y (pixel_y)
    );

    assign m_axis_tdata = {4'b0000, r_line_color, pixel_y, pixel_x};
    assign m_axis_tlast = stat.last;

`include "line_pixel_rasterizer_assert.svh"

    `LPR_ASSERT_IMPL(a_one_side, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "cmd ready while pixels pending")
    `LPR_ASSERT_NEXT(a_disabled_drop, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !r_line_enabled, s_axis_tready && !m_axis_tvalid, "disabled cmd produced output")
    `LPR_ASSERT_NEXT(a_setup_gap, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && r_line_enabled, !s_axis_tready && !m_axis_tvalid, "no setup cycle after cmd beat")
    `LPR_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready && !m_axis_tvalid, "not idle after last pixel beat")

endmodule
`default_nettype wire
